// ===== sv/mwd_pkg.sv =====
// Shared types and constants for the multiword by word divider.
package mwd_pkg;

  localparam int unsigned WordBits = 64;
  localparam int unsigned PortBits = 64;
  localparam int unsigned CountBits = $clog2(2 * WordBits);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BUSY,
    ST_HOLD
  } top_state_e;

  typedef struct packed {
    logic start;
    logic full_width;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== sv/mwd_div_unit.sv =====
// Radix-2 restoring divider that retires one quotient bit per cycle.
module mwd_div_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  mwd_pkg::div_ctrl_t               ctrl_i,
  input  logic [mwd_pkg::WordBits-1:0]     hi_i,
  input  logic [mwd_pkg::WordBits-1:0]     lo_i,
  input  logic [mwd_pkg::WordBits-1:0]     divisor_i,
  output mwd_pkg::div_stat_t               stat_o,
  output logic [mwd_pkg::WordBits-1:0]     quo_o,
  output logic [mwd_pkg::WordBits-1:0]     rem_o
);
  import mwd_pkg::*;

  logic [WordBits-1:0]   rem_q, rem_d;
  logic [WordBits-1:0]   quo_q, quo_d;
  logic [2*WordBits-1:0] num_q, num_d;
  logic [CountBits-1:0]  count_q, count_d;
  logic                  busy_q, busy_d;
  logic                  done_q, done_d;

  logic [WordBits-1:0]   shifted;
  logic                  carry;
  logic                  take;

  always_comb begin
    carry   = rem_q[WordBits-1];
    shifted = {rem_q[WordBits-2:0], num_q[2*WordBits-1]};
    // The bit shifted out of the top counts as part of the partial remainder.
    take    = carry || (shifted >= divisor_i);

    rem_d   = rem_q;
    quo_d   = quo_q;
    num_d   = num_q;
    count_d = count_q;
    busy_d  = busy_q;
    done_d  = 1'b0;

    if (ctrl_i.start) begin
      busy_d = 1'b1;
      quo_d  = '0;
      if (ctrl_i.full_width) begin
        rem_d   = '0;
        num_d   = {hi_i, lo_i};
        count_d = CountBits'(2 * WordBits - 1);
      end else begin
        // A high word below the divisor passes the upper half unchanged.
        rem_d   = hi_i;
        num_d   = {lo_i, {WordBits{1'b0}}};
        count_d = CountBits'(WordBits - 1);
      end
    end else if (busy_q) begin
      rem_d   = take ? (shifted - divisor_i) : shifted;
      quo_d   = {quo_q[WordBits-2:0], take};
      num_d   = {num_q[2*WordBits-2:0], 1'b0};
      count_d = count_q - 1'b1;
      if (count_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q   <= rem_d;
    quo_q   <= quo_d;
    num_q   <= num_d;
    count_q <= count_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quo_o       = quo_q;
  assign rem_o       = rem_q;

endmodule

// ===== sv/multiword_by_word_divider_top.sv =====
// Top level of the multiword by word short divider.
//
// Channel   Direction  Signals                           Contents
// s_axis    in         tvalid tready tdata tuser tlast   dividend word, first flag, final flag
// m_axis    out        tvalid tready tdata tlast         quotient word, last flag
// divisor   in         divisor_we_i divisor_i            divisor register, reset value 1
//
// A word that leads to a division passes through the one-bit-per-cycle restoring divider,
// and the result is then handed over to the output register. When the running
// remainder is not below the divisor the divider walks all 128 dividend bits.
// A leading word below the divisor that is not also the final word only seeds the remainder.
// Reset clears the remainder and sets the divisor to one. A stalled output holds the
// result in the divider, and no new word is taken until it moves to the output register.
module multiword_by_word_divider_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          divisor_we_i,
  input  logic [mwd_pkg::PortBits-1:0]  divisor_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [mwd_pkg::PortBits-1:0]  s_axis_tdata,   // [63:0] dividend_word
  input  logic                          s_axis_tuser,   // [0] first_word
  input  logic                          s_axis_tlast,   // final_word
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [mwd_pkg::PortBits-1:0]  m_axis_tdata,   // [63:0] quotient_word
  output logic                          m_axis_tlast    // quotient_last
);
  import mwd_pkg::*;

  top_state_e          state_q, state_d;
  logic [WordBits-1:0] divisor_q;
  logic [WordBits-1:0] rem_q, rem_d;
  logic                last_q, last_d;
  logic [WordBits-1:0] out_data_q, out_data_d;
  logic                out_last_q, out_last_d;
  logic                out_valid_q, out_valid_d;

  div_ctrl_t           div_ctrl;
  div_stat_t           div_stat;
  logic [WordBits-1:0] div_hi;
  logic [WordBits-1:0] div_quo;
  logic [WordBits-1:0] div_rem;

  logic [WordBits-1:0] word;
  logic                out_free;

  assign word     = s_axis_tdata[WordBits-1:0];
  assign out_free = !out_valid_q || m_axis_tready;
  assign div_hi   = s_axis_tuser ? '0 : rem_q;

  always_comb begin
    state_d        = state_q;
    rem_d          = rem_q;
    last_d         = last_q;
    out_data_d     = out_data_q;
    out_last_d     = out_last_q;
    out_valid_d    = out_valid_q && !m_axis_tready;
    div_ctrl.start = 1'b0;
    // The upper half can be skipped when it cannot produce a quotient bit.
    div_ctrl.full_width = !((div_hi < divisor_q) || (divisor_q == '0));
    s_axis_tready  = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          if (s_axis_tuser && !s_axis_tlast && (word < divisor_q)) begin
            rem_d = word;
          end else begin
            div_ctrl.start = 1'b1;
            last_d         = s_axis_tlast;
            state_d        = ST_BUSY;
          end
        end
      end
      ST_BUSY, ST_HOLD: begin
        if (div_stat.done || state_q == ST_HOLD) begin
          rem_d = div_rem;
          if (out_free) begin
            out_data_d  = div_quo;
            out_last_d  = last_q;
            out_valid_d = 1'b1;
            state_d     = ST_IDLE;
          end else begin
            state_d = ST_HOLD;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      divisor_q   <= WordBits'(1);
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
      if (divisor_we_i) begin
        divisor_q <= divisor_i[WordBits-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    last_q     <= last_d;
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
  end

  mwd_div_unit u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (div_ctrl),
    .hi_i      (div_hi),
    .lo_i      (word),
    .divisor_i (divisor_q),
    .stat_o    (div_stat),
    .quo_o     (div_quo),
    .rem_o     (div_rem)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = PortBits'(out_data_q);
  assign m_axis_tlast  = out_last_q;

endmodule
